// ===== hdl/fvtns_pkg.sv =====
// shared types, constants and arithmetic helpers for the four-voice synth
// no dependencies; used by every module under hdl
package fvtns_pkg;

  localparam int unsigned VOICE_COUNT_DEF = 4;
  localparam int unsigned PHASE_BITS_DEF  = 24;

  localparam int unsigned PITCH_W  = 7;
  localparam int unsigned STOP_W   = 32;
  localparam int unsigned SUB_W    = 13;
  localparam int unsigned SCALE_W  = 8;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned PROD_W   = 33;
  localparam int unsigned TERM_W   = PROD_W - 16;
  localparam int unsigned ACC_W    = 24;

  localparam logic [SUB_W-1:0]   SPT_RESET = 13'd5217;
  localparam logic [SCALE_W-1:0] NLS_RESET = 8'd64;
  localparam logic [7:0]         PITCH_OFFSET = 8'd47;
  localparam logic [7:0]         NOISE_CODE   = 8'd33;
  localparam logic signed [15:0] VOICE_GAIN = 16'sd13107;
  localparam logic [12:0]        NOISE_GAIN_MAX = 13'd6554;
  localparam logic signed [ACC_W-1:0] SAT_HI = 24'sd32767;
  localparam logic signed [ACC_W-1:0] SAT_LO = -24'sd32768;

  localparam logic [31:0] PITCH_ROM [12] = '{
    32'd37160835, 32'd39370534, 32'd41711627, 32'd44191930,
    32'd46819719, 32'd49603764, 32'd52553357, 32'd55678342,
    32'd58989149, 32'd62496826, 32'd66213081, 32'd70150316
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SAMPLES_PER_TICK   = 2'd0,
    CFG_NOISE_LENGTH_SCALE = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    logic        operation;
    logic [15:0] note_word;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] audio_sample;
    logic [3:0]         next_delay;
    logic               voice_dropped;
  } out_word_t;

  typedef struct packed {
    logic alloc;
    logic update;
    logic read;
    logic retire;
  } vs_ctrl_t;

  typedef struct packed {
    logic load;
    logic step;
    logic lfsr_step;
  } noise_ctrl_t;

  // product >> 16, rounded half up
  function automatic logic signed [TERM_W-1:0] scale16(input logic signed [PROD_W-1:0] x);
    logic signed [PROD_W-1:0] s;
    s = x + $signed(PROD_W'(32'd32768));
    return $signed(s[PROD_W-1:16]);
  endfunction

  // phase step per sample for a stored pitch, in pbits-bit turns
  function automatic logic [31:0] phase_inc(input logic [PITCH_W-1:0] pitch,
                                            input int unsigned pbits);
    logic [1:0]  oct;
    logic [6:0]  idx7;
    logic [31:0] base;
    logic [5:0]  shift;
    logic [32:0] sum;
    if (pitch < 7'd47 || pitch > 7'd79) begin
      return 32'd0;
    end
    oct = (pitch >= 7'd68) ? 2'd0 : ((pitch >= 7'd56) ? 2'd1 : 2'd2);
    idx7 = pitch + 7'(12 * oct) - 7'd68;
    base = PITCH_ROM[idx7[3:0]];
    shift = 6'(oct) + 6'(32 - pbits);
    if (shift == 6'd0) begin
      return base;
    end
    sum = {1'b0, base} + (33'd1 << (shift - 6'd1));
    return 32'(sum >> shift);
  endfunction

endpackage

// ===== hdl/fvtns_voice_store.sv =====
// voice table memory (pitch, stop tick, phase) with busy flags and free-voice search
// depends on fvtns_pkg
module fvtns_voice_store #(
  parameter int unsigned VOICE_COUNT = fvtns_pkg::VOICE_COUNT_DEF,
  parameter int unsigned PHASE_BITS  = fvtns_pkg::PHASE_BITS_DEF,
  localparam int unsigned IDX_W   = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1,
  localparam int unsigned ENTRY_W = fvtns_pkg::PITCH_W + fvtns_pkg::STOP_W + PHASE_BITS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  fvtns_pkg::vs_ctrl_t    ctrl_i,
  input  logic [IDX_W-1:0]       rd_addr_i,
  input  logic [IDX_W-1:0]       wr_addr_i,
  input  logic [ENTRY_W-1:0]     wr_data_i,
  output logic [ENTRY_W-1:0]     rd_data_o,
  output logic [VOICE_COUNT-1:0] busy_o,
  output logic                   full_o
);

  logic [ENTRY_W-1:0]     mem_q [VOICE_COUNT];
  logic [ENTRY_W-1:0]     rd_data_q;
  logic [VOICE_COUNT-1:0] busy_q;
  logic [IDX_W-1:0]       free_idx;
  logic                   found;

  always_comb begin
    free_idx = '0;
    found    = 1'b0;
    for (int i = 0; i < VOICE_COUNT; i++) begin
      if (!busy_q[i] && !found) begin
        free_idx = IDX_W'(i);
        found    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.alloc) begin
      mem_q[free_idx] <= wr_data_i;
    end else if (ctrl_i.update) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (ctrl_i.read) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= '0;
    end else begin
      if (ctrl_i.alloc) begin
        busy_q[free_idx] <= 1'b1;
      end
      if (ctrl_i.retire) begin
        busy_q[wr_addr_i] <= 1'b0;
      end
    end
  end

  assign rd_data_o = rd_data_q;
  assign busy_o    = busy_q;
  assign full_o    = &busy_q;

endmodule

// ===== hdl/fvtns_noise.sv =====
// noise channel: lfsr, burst length counter and gain-scaled noise product
// depends on fvtns_pkg
module fvtns_noise (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  fvtns_pkg::noise_ctrl_t                ctrl_i,
  input  logic [4:0]                            dur_i,
  input  logic [fvtns_pkg::SCALE_W-1:0]         scale_i,
  output logic signed [fvtns_pkg::TERM_W-1:0]   term_o
);

  logic [15:0]                          lfsr_q;
  logic [23:0]                          remain_q;
  logic                                 armed_q;
  logic signed [fvtns_pkg::PROD_W-1:0]  prod_q;
  logic [27:0]                          remain_x16;
  logic [12:0]                          gain;
  logic signed [15:0]                   nval;
  logic signed [29:0]                   nprod;
  logic                                 fb;
  logic [13:0]                          burst_len;

  assign remain_x16 = {remain_q, 4'b0000};
  assign gain = (remain_x16 > 28'(fvtns_pkg::NOISE_GAIN_MAX))
              ? fvtns_pkg::NOISE_GAIN_MAX : remain_x16[12:0];
  assign nval  = $signed({1'b0, lfsr_q[15:1]}) - 16'sd16384;
  assign nprod = nval * $signed({1'b0, gain});
  assign fb    = lfsr_q[0] ^ lfsr_q[2] ^ lfsr_q[3] ^ lfsr_q[5];
  assign burst_len = ({9'd0, dur_i} + 14'd1) * {6'd0, scale_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lfsr_q   <= 16'd1;
      remain_q <= '0;
      armed_q  <= 1'b0;
      prod_q   <= '0;
    end else if (ctrl_i.load) begin
      armed_q  <= 1'b1;
      remain_q <= 24'(burst_len);
    end else if (ctrl_i.step) begin
      if (armed_q) begin
        prod_q <= fvtns_pkg::PROD_W'(nprod);
        if (ctrl_i.lfsr_step) begin
          lfsr_q <= {fb, lfsr_q[15:1]};
        end
        if (remain_q != '0) begin
          remain_q <= remain_q - 24'd1;
        end
      end else begin
        prod_q <= '0;
      end
    end
  end

  assign term_o = fvtns_pkg::scale16(prod_q);

endmodule

// ===== hdl/four_voice_triangle_noise_synth.sv =====
// top level: item sequencer, voice mixing pipeline, tick counters and output register
// depends on fvtns_pkg, fvtns_voice_store, fvtns_noise
//
// A note word is accepted, then allocates a voice from the busy flags (or arms the noise
// burst) and loads the result. A sample request is accepted, then the voice memory is read,
// one read per cycle for each voice; each voice's triangle product and phase write-back follow
// its read, then its accumulate. A check that sees the voice pipeline empty follows, and a final
// state adds the noise term, saturates and advances the tick. A voice's accumulate is skipped
// when that voice is free. Only one item is in work at a time; a finished word sits in the output
// register, so the next item is taken while it waits, and that item holds in its last cycle
// until the register frees. The voice memory needs no clearing pass: free voices are tracked by
// busy flags cleared at reset.
module four_voice_triangle_noise_synth #(
  parameter int unsigned VOICE_COUNT = fvtns_pkg::VOICE_COUNT_DEF,
  parameter int unsigned PHASE_BITS  = fvtns_pkg::PHASE_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  fvtns_pkg::in_word_t                 in_word_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output fvtns_pkg::out_word_t                out_word_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [fvtns_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [fvtns_pkg::SUB_W-1:0]         cfg_data_i
);

  localparam int unsigned IDX_W   = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
  localparam int unsigned CNT_W   = $clog2(VOICE_COUNT + 1);
  localparam int unsigned ENTRY_W = fvtns_pkg::PITCH_W + fvtns_pkg::STOP_W + PHASE_BITS;
  localparam int unsigned PB      = PHASE_BITS;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_NOTE = 4'b0010,
    ST_MIX  = 4'b0100,
    ST_FIN  = 4'b1000
  } state_e;

  state_e                              state_q;
  fvtns_pkg::in_word_t                 item_q;
  logic [fvtns_pkg::SUB_W-1:0]         spt_q;
  logic [fvtns_pkg::SCALE_W-1:0]       nls_q;
  logic [31:0]                         tick_q;
  logic [fvtns_pkg::SUB_W-1:0]         sub_q;
  logic [CNT_W-1:0]                    rd_cnt_q;
  logic                                s1_vld_q;
  logic [IDX_W-1:0]                    s1_idx_q;
  logic                                p_vld_q;
  logic signed [fvtns_pkg::PROD_W-1:0] p_q;
  logic signed [fvtns_pkg::ACC_W-1:0]  acc_q;
  logic                                out_valid_q;
  fvtns_pkg::out_word_t                out_q;

  fvtns_pkg::vs_ctrl_t                 vs_ctrl;
  fvtns_pkg::noise_ctrl_t              nz_ctrl;
  logic [ENTRY_W-1:0]                  rd_data;
  logic [ENTRY_W-1:0]                  wr_data;
  logic [VOICE_COUNT-1:0]              busy;
  logic                                full;
  logic signed [fvtns_pkg::TERM_W-1:0] noise_term;

  logic                                in_acc;
  logic                                out_free;
  logic                                out_load;
  logic [8:0]                          pitch9;
  logic                                tone;
  logic [4:0]                          dur;
  logic [31:0]                         stop_new;
  logic                                issue;
  logic                                wrap;
  logic [31:0]                         tick_next;
  logic [fvtns_pkg::PITCH_W-1:0]       v_pitch;
  logic [31:0]                         v_stop;
  logic [PB-1:0]                       v_phase;
  logic [31:0]                         v_inc;
  logic [15:0]                         u;
  logic signed [17:0]                  tri18;
  logic signed [16:0]                  tri_v;
  logic signed [fvtns_pkg::PROD_W-1:0] v_prod;
  logic [31:0]                         age;
  logic                                mix_done;
  logic signed [fvtns_pkg::ACC_W-1:0]  total;
  logic signed [fvtns_pkg::ACC_W-1:0]  total_sat;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_load    = ((state_q == ST_NOTE) || (state_q == ST_FIN)) && out_free;
  assign cfg_ready_o = 1'b1;

  // note word decode
  assign pitch9   = {1'b0, item_q.note_word[15:8]} + {1'b0, fvtns_pkg::PITCH_OFFSET};
  assign tone     = item_q.note_word[15:8] < fvtns_pkg::NOISE_CODE;
  assign dur      = item_q.note_word[7:3];
  assign stop_new = tick_q + 32'(dur) + 32'd1;

  // tick boundary
  assign wrap      = ({1'b0, sub_q} + 14'd1) >= {1'b0, spt_q};
  assign tick_next = tick_q + 32'd1;

  // voice stage one: data from memory
  assign v_pitch = rd_data[ENTRY_W-1 -: fvtns_pkg::PITCH_W];
  assign v_stop  = rd_data[PB +: fvtns_pkg::STOP_W];
  assign v_phase = rd_data[PB-1:0];
  assign v_inc   = fvtns_pkg::phase_inc(v_pitch, PHASE_BITS);
  assign u       = v_phase[PB-1 -: 16];
  assign tri18   = u[15] ? (18'sd98304 - $signed({1'b0, u, 1'b0}))
                         : ($signed({1'b0, u, 1'b0}) - 18'sd32768);
  assign tri_v   = tri18[16:0];
  assign v_prod  = tri_v * fvtns_pkg::VOICE_GAIN;
  assign age     = tick_next - v_stop;

  assign issue    = (state_q == ST_MIX) && (rd_cnt_q < CNT_W'(VOICE_COUNT));
  assign mix_done = (rd_cnt_q == CNT_W'(VOICE_COUNT)) && !s1_vld_q && !p_vld_q;

  always_comb begin
    vs_ctrl.alloc  = (state_q == ST_NOTE) && out_free && tone && !full;
    vs_ctrl.read   = issue;
    vs_ctrl.update = (state_q == ST_MIX) && s1_vld_q && busy[s1_idx_q];
    vs_ctrl.retire = vs_ctrl.update && wrap && !age[31];
    if (state_q == ST_NOTE) begin
      wr_data = {pitch9[fvtns_pkg::PITCH_W-1:0], stop_new, {PB{1'b0}}};
    end else begin
      wr_data = {v_pitch, v_stop, v_phase + v_inc[PB-1:0]};
    end
  end

  always_comb begin
    nz_ctrl.load      = (state_q == ST_NOTE) && out_free && !tone;
    nz_ctrl.step      = (state_q == ST_MIX) && (rd_cnt_q == '0);
    nz_ctrl.lfsr_step = (sub_q[2:0] == 3'd0);
  end

  always_comb begin
    total = acc_q + fvtns_pkg::ACC_W'(noise_term);
    if (total > fvtns_pkg::SAT_HI) begin
      total_sat = fvtns_pkg::SAT_HI;
    end else if (total < fvtns_pkg::SAT_LO) begin
      total_sat = fvtns_pkg::SAT_LO;
    end else begin
      total_sat = total;
    end
  end

  fvtns_voice_store #(
    .VOICE_COUNT(VOICE_COUNT),
    .PHASE_BITS (PHASE_BITS)
  ) u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (vs_ctrl),
    .rd_addr_i(rd_cnt_q[IDX_W-1:0]),
    .wr_addr_i(s1_idx_q),
    .wr_data_i(wr_data),
    .rd_data_o(rd_data),
    .busy_o   (busy),
    .full_o   (full)
  );

  fvtns_noise u_noise (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (nz_ctrl),
    .dur_i  (dur),
    .scale_i(nls_q),
    .term_o (noise_term)
  );

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spt_q <= fvtns_pkg::SPT_RESET;
      nls_q <= fvtns_pkg::NLS_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        fvtns_pkg::CFG_SAMPLES_PER_TICK:   spt_q <= cfg_data_i;
        fvtns_pkg::CFG_NOISE_LENGTH_SCALE: nls_q <= cfg_data_i[fvtns_pkg::SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q <= in_word_i;
    end
    if (state_q == ST_MIX && s1_vld_q) begin
      p_q <= v_prod;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tick_q      <= '0;
      sub_q       <= '0;
      rd_cnt_q    <= '0;
      s1_vld_q    <= 1'b0;
      s1_idx_q    <= '0;
      p_vld_q     <= 1'b0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            rd_cnt_q <= '0;
            acc_q    <= '0;
            state_q  <= in_word_i.operation ? ST_MIX : ST_NOTE;
          end
        end
        ST_NOTE: begin
          if (out_free) begin
            out_q.audio_sample  <= '0;
            out_q.next_delay    <= (item_q.note_word[2:0] == 3'd7)
                                 ? 4'd8 : {1'b0, item_q.note_word[2:0]};
            out_q.voice_dropped <= tone && full;
            state_q             <= ST_IDLE;
          end
        end
        ST_MIX: begin
          s1_vld_q <= issue;
          s1_idx_q <= rd_cnt_q[IDX_W-1:0];
          if (issue) begin
            rd_cnt_q <= rd_cnt_q + CNT_W'(1);
          end
          p_vld_q <= s1_vld_q && busy[s1_idx_q];
          if (p_vld_q) begin
            acc_q <= acc_q + fvtns_pkg::ACC_W'(fvtns_pkg::scale16(p_q));
          end
          if (mix_done) begin
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            out_q.audio_sample  <= total_sat[15:0];
            out_q.next_delay    <= '0;
            out_q.voice_dropped <= 1'b0;
            if (wrap) begin
              sub_q  <= '0;
              tick_q <= tick_next;
            end else begin
              sub_q <= sub_q + fvtns_pkg::SUB_W'(1);
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  a_out_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_NOTE || $past(state_q) == ST_FIN))
    else $error("output word loaded outside a finishing state");

  a_pipe_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FIN |-> (!s1_vld_q && !p_vld_q))
    else $error("sample finished with voice work still in flight");

  a_no_same_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vs_ctrl.read && vs_ctrl.update) |-> (rd_cnt_q[IDX_W-1:0] != s1_idx_q))
    else $error("voice memory read and write-back hit the same entry");

  a_alloc_only_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vs_ctrl.alloc |-> !full)
    else $error("voice allocated with every voice busy");

endmodule
